### src/acdu_pkg.sv
// Shared constants, types and the month table for the alarm countdown difference unit.
// No dependencies; the day count, day split, time-of-day and top-level files import this package.
package acdu_pkg;

    // Register stages from the input register to the result register
    localparam int STAGES = 8;

    localparam int YEAR_W   = 14;
    localparam int DAYCNT_W = 22;
    localparam int TOD_W    = 17;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [4:0]  DAYS_PER_MONTH = 5'd30;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [4:0]  HOUR_MAX       = 5'd23;
    localparam logic [5:0]  MINSEC_MAX     = 6'd59;

    // Reciprocal constants: q = (x * RECIP) >> SHIFT is exact over each value range used
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          SHIFT_100  = 19;
    localparam logic [22:0] RECIP_365  = 23'd5883517;
    localparam int          SHIFT_365  = 31;
    localparam logic [16:0] RECIP_3600 = 17'd74566;
    localparam int          SHIFT_3600 = 28;
    localparam logic [9:0]  RECIP_30   = 10'd547;
    localparam int          SHIFT_30   = 14;
    localparam logic [12:0] RECIP_60   = 13'd4370;
    localparam int          SHIFT_60   = 18;

    // Per-stage load enables, stage 1 is the input register
    typedef struct packed {
        logic [STAGES:1] ld;
    } acdu_ctrl_t;

    // Days before month m in a common year; months past December count 31 days
    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            4'd13:   base = 9'd365;
            4'd14:   base = 9'd396;
            default: base = 9'd427;
        endcase
        return base;
    endfunction

endpackage

### src/acdu_day_count.sv
// Two-stage day count of one date from year 0 (stages 2 and 3).
// Depends on acdu_pkg for the month table, constants and the stage control struct.
module acdu_day_count import acdu_pkg::*; (
    input  logic                aclk,
    input  acdu_ctrl_t          ctrl,
    input  logic [4:0]          day,
    input  logic [3:0]          month,
    input  logic [YEAR_W-1:0]   year,
    output logic [DAYCNT_W-1:0] count
);

    logic [YEAR_W-1:0]   y_clamp;
    logic [26:0]         prod100;
    logic [YEAR_W-1:0]   y_reg;
    logic [6:0]          q100_reg;
    logic [3:0]          month_reg;
    logic [4:0]          day_reg;

    logic [YEAR_W-1:0]   hund;
    logic                r_nz;
    logic                q400_frac;
    logic                leap;
    logic [YEAR_W:0]     y3;
    logic [DAYCNT_W-1:0] count_next;
    logic [DAYCNT_W-1:0] count_reg;

    // Stage 2: clamp the year and take the century
    always_comb begin
        y_clamp = (year > MAX_YEAR) ? MAX_YEAR : year;
        prod100 = 27'(y_clamp) * 27'(RECIP_100);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[2]) begin
            y_reg     <= y_clamp;
            q100_reg  <= prod100[SHIFT_100 +: 7];
            month_reg <= month;
            day_reg   <= day;
        end
    end

    // Stage 3: leap years before y are ceil(y/4) - ceil(y/100) + ceil(y/400)
    always_comb begin
        hund      = 14'(q100_reg) * 14'(YEARS_PER_CENT);
        r_nz      = (y_reg != hund);
        q400_frac = r_nz || (q100_reg[1:0] != 2'd0);
        leap      = (y_reg[1:0] == 2'd0) && (r_nz || (q100_reg[1:0] == 2'd0));
        y3        = {1'b0, y_reg} + 15'd3;
        count_next = 22'(y_reg) * 22'(DAYS_PER_YEAR)
                   + 22'(y3[YEAR_W:2])
                   - 22'(q100_reg) - 22'(r_nz)
                   + 22'(q100_reg[6:2]) + 22'(q400_frac)
                   + 22'(month_base(month_reg))
                   + 22'(leap && (month_reg > 4'd2))
                   + 22'(day_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[3]) begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

### src/acdu_day_split.sv
// Signed day difference split into years, months and days (stages 4 to 8).
// Depends on acdu_pkg for the reciprocal constants and the stage control struct.
module acdu_day_split import acdu_pkg::*; (
    input  logic                aclk,
    input  acdu_ctrl_t          ctrl,
    input  logic [DAYCNT_W-1:0] cnt_alarm,
    input  logic [DAYCNT_W-1:0] cnt_now,
    output logic signed [14:0]  diff_years,
    output logic signed [4:0]   diff_months,
    output logic signed [5:0]   diff_days
);

    logic [DAYCNT_W:0]   diff;
    logic [DAYCNT_W:0]   diff_neg;
    logic                neg4_reg;
    logic [DAYCNT_W-1:0] abs4_reg;

    logic [44:0]         prod365;
    logic                neg5_reg;
    logic [DAYCNT_W-1:0] abs5_reg;
    logic [13:0]         yrs5_reg;

    logic [DAYCNT_W-1:0] rem_full;
    logic                neg6_reg;
    logic [13:0]         yrs6_reg;
    logic [8:0]          rem6_reg;

    logic [18:0]         prod30;
    logic                neg7_reg;
    logic [13:0]         yrs7_reg;
    logic [8:0]          rem7_reg;
    logic [3:0]          mon7_reg;

    logic [8:0]          dys_full;
    logic [14:0]         yrs_mag;
    logic [4:0]          mon_mag;
    logic [5:0]          dys_mag;
    logic [14:0]         years_next;
    logic [4:0]          months_next;
    logic [5:0]          days_next;
    logic signed [14:0]  years_reg;
    logic signed [4:0]   months_reg;
    logic signed [5:0]   days_reg;

    // Stage 4: work on the magnitude, truncation toward zero keeps the sign apart
    always_comb begin
        diff     = {1'b0, cnt_alarm} - {1'b0, cnt_now};
        diff_neg = -diff;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[4]) begin
            neg4_reg <= diff[DAYCNT_W];
            abs4_reg <= diff[DAYCNT_W] ? diff_neg[DAYCNT_W-1:0] : diff[DAYCNT_W-1:0];
        end
    end

    // Stage 5: years
    assign prod365 = 45'(abs4_reg) * 45'(RECIP_365);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[5]) begin
            neg5_reg <= neg4_reg;
            abs5_reg <= abs4_reg;
            yrs5_reg <= prod365[SHIFT_365 +: 14];
        end
    end

    // Stage 6: remainder of the year
    assign rem_full = abs5_reg - 22'(yrs5_reg) * 22'(DAYS_PER_YEAR);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[6]) begin
            neg6_reg <= neg5_reg;
            yrs6_reg <= yrs5_reg;
            rem6_reg <= rem_full[8:0];
        end
    end

    // Stage 7: months of 30 days
    assign prod30 = 19'(rem6_reg) * 19'(RECIP_30);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[7]) begin
            neg7_reg <= neg6_reg;
            yrs7_reg <= yrs6_reg;
            rem7_reg <= rem6_reg;
            mon7_reg <= prod30[SHIFT_30 +: 4];
        end
    end

    // Stage 8: days, then restore the sign on every part
    always_comb begin
        dys_full    = rem7_reg - 9'(mon7_reg) * 9'(DAYS_PER_MONTH);
        yrs_mag     = {1'b0, yrs7_reg};
        mon_mag     = {1'b0, mon7_reg};
        dys_mag     = {1'b0, dys_full[4:0]};
        years_next  = neg7_reg ? -yrs_mag : yrs_mag;
        months_next = neg7_reg ? -mon_mag : mon_mag;
        days_next   = neg7_reg ? -dys_mag : dys_mag;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld[8]) begin
            years_reg  <= years_next;
            months_reg <= months_next;
            days_reg   <= days_next;
        end
    end

    assign diff_years  = years_reg;
    assign diff_months = months_reg;
    assign diff_days   = days_reg;

endmodule

### src/acdu_tod_diff.sv
// Absolute time-of-day difference as hours, minutes and seconds (stages 2 to 8).
// Depends on acdu_pkg for the reciprocal constants and the stage control struct.
module acdu_tod_diff import acdu_pkg::*; (
    input  logic       aclk,
    input  acdu_ctrl_t ctrl,
    input  logic [4:0] now_hour,
    input  logic [5:0] now_minute,
    input  logic [5:0] now_second,
    input  logic [4:0] alarm_hour,
    input  logic [5:0] alarm_minute,
    input  logic [5:0] alarm_second,
    output logic [4:0] diff_hours,
    output logic [5:0] diff_minutes,
    output logic [5:0] diff_seconds
);

    function automatic logic [TOD_W-1:0] tod_seconds(input logic [4:0] h,
                                                     input logic [5:0] m,
                                                     input logic [5:0] s);
        logic [4:0] hs;
        logic [5:0] ms;
        logic [5:0] ss;
        hs = (h > HOUR_MAX)   ? HOUR_MAX   : h;
        ms = (m > MINSEC_MAX) ? MINSEC_MAX : m;
        ss = (s > MINSEC_MAX) ? MINSEC_MAX : s;
        return 17'(hs) * 17'(SECS_PER_HOUR) + 17'(ms) * 17'(SECS_PER_MIN) + 17'(ss);
    endfunction

    logic [TOD_W-1:0] ts2_reg;
    logic [TOD_W-1:0] te2_reg;
    logic [TOD_W-1:0] td3_reg;
    logic [33:0]      prod3600;
    logic [TOD_W-1:0] td4_reg;
    logic [4:0]       hrs4_reg;
    logic [TOD_W-1:0] rem_full;
    logic [4:0]       hrs5_reg;
    logic [11:0]      rem5_reg;
    logic [24:0]      prod60;
    logic [4:0]       hrs6_reg;
    logic [11:0]      rem6_reg;
    logic [5:0]       min6_reg;
    logic [11:0]      sec_full;
    logic [4:0]       hrs7_reg;
    logic [5:0]       min7_reg;
    logic [5:0]       sec7_reg;
    logic [4:0]       hours_reg;
    logic [5:0]       minutes_reg;
    logic [5:0]       seconds_reg;

    // Stage 2: saturate and convert to seconds of day
    always_ff @(posedge aclk) begin
        if (ctrl.ld[2]) begin
            ts2_reg <= tod_seconds(now_hour, now_minute, now_second);
            te2_reg <= tod_seconds(alarm_hour, alarm_minute, alarm_second);
        end
    end

    // Stage 3: absolute difference, no borrow into the day count
    always_ff @(posedge aclk) begin
        if (ctrl.ld[3]) begin
            td3_reg <= (te2_reg >= ts2_reg) ? te2_reg - ts2_reg : ts2_reg - te2_reg;
        end
    end

    // Stage 4: hours
    assign prod3600 = 34'(td3_reg) * 34'(RECIP_3600);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[4]) begin
            td4_reg  <= td3_reg;
            hrs4_reg <= prod3600[SHIFT_3600 +: 5];
        end
    end

    // Stage 5: seconds within the hour
    assign rem_full = td4_reg - 17'(hrs4_reg) * 17'(SECS_PER_HOUR);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[5]) begin
            hrs5_reg <= hrs4_reg;
            rem5_reg <= rem_full[11:0];
        end
    end

    // Stage 6: minutes
    assign prod60 = 25'(rem5_reg) * 25'(RECIP_60);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[6]) begin
            hrs6_reg <= hrs5_reg;
            rem6_reg <= rem5_reg;
            min6_reg <= prod60[SHIFT_60 +: 6];
        end
    end

    // Stage 7: seconds
    assign sec_full = rem6_reg - 12'(min6_reg) * 12'(SECS_PER_MIN);

    always_ff @(posedge aclk) begin
        if (ctrl.ld[7]) begin
            hrs7_reg <= hrs6_reg;
            min7_reg <= min6_reg;
            sec7_reg <= sec_full[5:0];
        end
    end

    // Stage 8: result register
    always_ff @(posedge aclk) begin
        if (ctrl.ld[8]) begin
            hours_reg   <= hrs7_reg;
            minutes_reg <= min7_reg;
            seconds_reg <= sec7_reg;
        end
    end

    assign diff_hours   = hours_reg;
    assign diff_minutes = minutes_reg;
    assign diff_seconds = seconds_reg;

endmodule

### src/alarm_countdown_difference_unit.sv
// Top level of the alarm countdown difference unit: input register, stage control,
// day count, day split and time-of-day paths. Depends on acdu_pkg and the acdu_* modules.
//
// Usage:
//   Input channel s_valid/s_ready carries one beat with a current date-time and an
//   alarm date-time. Result channel m_valid/m_ready carries one beat per input beat
//   with the signed year/month/day split of the day difference (alarm minus now)
//   and the absolute time-of-day difference as hours, minutes and seconds.
//   Throughput: one beat per cycle while the result side keeps up; the 8 stage registers each carry a valid bit.
//   Each stage loads when it is empty or the stage after it moves, so bubbles close
//   up and s_ready stays high while the result register waits, until all 8 stages
//   are full. With m_ready low long enough the pipeline fills and s_ready drops;
//   the held result and its payload stay stable until taken.
//   Reset (aresetn low, synchronous) empties all stages: m_valid drops at the next
//   edge and s_ready is high after it. Results of beats in flight are dropped.
module alarm_countdown_difference_unit import acdu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_now_day,
    input  logic [3:0]        s_now_month,
    input  logic [13:0]       s_now_year,
    input  logic [4:0]        s_now_hour,
    input  logic [5:0]        s_now_minute,
    input  logic [5:0]        s_now_second,
    input  logic [4:0]        s_alarm_day,
    input  logic [3:0]        s_alarm_month,
    input  logic [13:0]       s_alarm_year,
    input  logic [4:0]        s_alarm_hour,
    input  logic [5:0]        s_alarm_minute,
    input  logic [5:0]        s_alarm_second,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [14:0] m_diff_years,
    output logic signed [4:0]  m_diff_months,
    output logic signed [5:0]  m_diff_days,
    output logic [4:0]        m_diff_hours,
    output logic [5:0]        m_diff_minutes,
    output logic [5:0]        m_diff_seconds
);

    logic [STAGES:1]     valid_reg;
    logic [STAGES:1]     valid_next;
    logic [STAGES:1]     stage_rdy;
    acdu_ctrl_t          ctrl;

    logic [4:0]          now_day_reg;
    logic [3:0]          now_month_reg;
    logic [13:0]         now_year_reg;
    logic [4:0]          now_hour_reg;
    logic [5:0]          now_minute_reg;
    logic [5:0]          now_second_reg;
    logic [4:0]          alarm_day_reg;
    logic [3:0]          alarm_month_reg;
    logic [13:0]         alarm_year_reg;
    logic [4:0]          alarm_hour_reg;
    logic [5:0]          alarm_minute_reg;
    logic [5:0]          alarm_second_reg;

    logic [DAYCNT_W-1:0] cnt_now;
    logic [DAYCNT_W-1:0] cnt_alarm;

    // A stage takes a new beat when empty or when its own beat moves on
    always_comb begin
        stage_rdy[STAGES] = !valid_reg[STAGES] || m_ready;
        for (int i = STAGES - 1; i >= 1; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        valid_next[1] = stage_rdy[1] ? s_valid : valid_reg[1];
        for (int i = 2; i <= STAGES; i++) begin
            valid_next[i] = stage_rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
        ctrl.ld = stage_rdy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Input register, stage 1
    always_ff @(posedge aclk) begin
        if (ctrl.ld[1]) begin
            now_day_reg      <= s_now_day;
            now_month_reg    <= s_now_month;
            now_year_reg     <= s_now_year;
            now_hour_reg     <= s_now_hour;
            now_minute_reg   <= s_now_minute;
            now_second_reg   <= s_now_second;
            alarm_day_reg    <= s_alarm_day;
            alarm_month_reg  <= s_alarm_month;
            alarm_year_reg   <= s_alarm_year;
            alarm_hour_reg   <= s_alarm_hour;
            alarm_minute_reg <= s_alarm_minute;
            alarm_second_reg <= s_alarm_second;
        end
    end

    acdu_day_count u_count_now (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .day   (now_day_reg),
        .month (now_month_reg),
        .year  (now_year_reg),
        .count (cnt_now)
    );

    acdu_day_count u_count_alarm (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .day   (alarm_day_reg),
        .month (alarm_month_reg),
        .year  (alarm_year_reg),
        .count (cnt_alarm)
    );

    acdu_day_split u_split (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .cnt_alarm   (cnt_alarm),
        .cnt_now     (cnt_now),
        .diff_years  (m_diff_years),
        .diff_months (m_diff_months),
        .diff_days   (m_diff_days)
    );

    acdu_tod_diff u_tod (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .now_hour     (now_hour_reg),
        .now_minute   (now_minute_reg),
        .now_second   (now_second_reg),
        .alarm_hour   (alarm_hour_reg),
        .alarm_minute (alarm_minute_reg),
        .alarm_second (alarm_second_reg),
        .diff_hours   (m_diff_hours),
        .diff_minutes (m_diff_minutes),
        .diff_seconds (m_diff_seconds)
    );

    assign s_ready = stage_rdy[1];
    assign m_valid = valid_reg[STAGES];

endmodule

### src/acdu_checker.sv
// Port-level checker for the alarm countdown difference unit, bound to the top level.
// Depends only on the top level's ports.
module acdu_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [14:0] m_diff_years,
    input logic signed [4:0]  m_diff_months,
    input logic signed [5:0]  m_diff_days,
    input logic [4:0]        m_diff_hours,
    input logic [5:0]        m_diff_minutes,
    input logic [5:0]        m_diff_seconds
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Input backs up only when the result side stalls
    a_stall_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side free");

    // Year, month and day parts never disagree in sign
    a_sign_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !((m_diff_years > 0 || m_diff_months > 0 || m_diff_days > 0)
                      && (m_diff_years < 0 || m_diff_months < 0 || m_diff_days < 0)))
        else $error("mixed signs in day difference");

    // Time-of-day parts stay in range
    a_tod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_diff_hours <= 5'd23 && m_diff_minutes <= 6'd59
                    && m_diff_seconds <= 6'd59)
        else $error("time-of-day difference out of range");

    // Held result keeps its years, days and seconds payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_diff_years)
            && $stable(m_diff_days) && $stable(m_diff_seconds))
        else $error("result changed while stalled");

endmodule

bind alarm_countdown_difference_unit acdu_checker u_acdu_checker (.*);

### bench/acdu_countdown_checker.sv
// Result checker for the alarm countdown difference unit: watches both channels,
// predicts each countdown from the accepted date-time pair and compares it field by field.
// Stand-alone; only needs the unit's port widths.
`timescale 1ns / 100ps

module acdu_countdown_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [4:0]         s_now_day,
    input  logic [3:0]         s_now_month,
    input  logic [13:0]        s_now_year,
    input  logic [4:0]         s_now_hour,
    input  logic [5:0]         s_now_minute,
    input  logic [5:0]         s_now_second,
    input  logic [4:0]         s_alarm_day,
    input  logic [3:0]         s_alarm_month,
    input  logic [13:0]        s_alarm_year,
    input  logic [4:0]         s_alarm_hour,
    input  logic [5:0]         s_alarm_minute,
    input  logic [5:0]         s_alarm_second,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [14:0] m_diff_years,
    input  logic signed [4:0]  m_diff_months,
    input  logic signed [5:0]  m_diff_days,
    input  logic [4:0]         m_diff_hours,
    input  logic [5:0]         m_diff_minutes,
    input  logic [5:0]         m_diff_seconds,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int YEAR_CAP = 9999;

    typedef struct packed {
        logic signed [14:0] years;
        logic signed [4:0]  months;
        logic signed [5:0]  days;
        logic [4:0]         hours;
        logic [5:0]         minutes;
        logic [5:0]         seconds;
    } countdown_t;

    countdown_t countdown_q[$];
    int         results_seen = 0;

    function automatic bit is_leap(input int yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    function automatic int days_since_year0(input logic [4:0] day, input logic [3:0] month,
                                            input logic [13:0] year);
        int yr;
        int total;
        int k;
        yr = (year > YEAR_CAP) ? YEAR_CAP : int'(year);
        // whole years before this one, year 0 counting as leap
        total = yr * 365 + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
        // whole months before this one; anything past December is a 31-day month
        for (k = 1; k < int'(month); k++) begin
            if (k == 2)
                total += 28;
            else if (k == 4 || k == 6 || k == 9 || k == 11)
                total += 30;
            else
                total += 31;
        end
        if (month > 2 && is_leap(yr))
            total += 1;
        return total + int'(day);
    endfunction

    function automatic int tod_seconds(input logic [4:0] h, input logic [5:0] mi,
                                       input logic [5:0] s);
        int hh;
        int mm;
        int ss;
        hh = (h > 23) ? 23 : int'(h);
        mm = (mi > 59) ? 59 : int'(mi);
        ss = (s > 59) ? 59 : int'(s);
        return hh * 3600 + mm * 60 + ss;
    endfunction

    function automatic countdown_t countdown_of(
        input logic [4:0] nd, input logic [3:0] nm, input logic [13:0] ny,
        input logic [4:0] nh, input logic [5:0] nmin, input logic [5:0] nsec,
        input logic [4:0] ad, input logic [3:0] am, input logic [13:0] ay,
        input logic [4:0] ah, input logic [5:0] amin, input logic [5:0] asec);
        countdown_t c;
        int span;
        int rest;
        int gap;
        span = days_since_year0(ad, am, ay) - days_since_year0(nd, nm, ny);
        // C-style division: truncate toward zero, remainder takes the sign of span
        rest = span % 365;
        c.years  = 15'(span / 365);
        c.months = 5'(rest / 30);
        c.days   = 6'(rest % 30);
        gap = tod_seconds(ah, amin, asec) - tod_seconds(nh, nmin, nsec);
        if (gap < 0)
            gap = -gap;
        c.hours   = 5'(gap / 3600);
        c.minutes = 6'((gap % 3600) / 60);
        c.seconds = 6'(gap % 60);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("result beat %0d: %s", results_seen, msg);
    endtask

    always @(posedge aclk) begin
        countdown_t want;
        if (!aresetn) begin
            countdown_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (countdown_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending");
                end else begin
                    want = countdown_q.pop_front();
                    if (m_diff_years !== want.years)
                        report_mismatch($sformatf("diff_years %0d, expected %0d",
                                                  m_diff_years, want.years));
                    if (m_diff_months !== want.months)
                        report_mismatch($sformatf("diff_months %0d, expected %0d",
                                                  m_diff_months, want.months));
                    if (m_diff_days !== want.days)
                        report_mismatch($sformatf("diff_days %0d, expected %0d",
                                                  m_diff_days, want.days));
                    if (m_diff_hours !== want.hours)
                        report_mismatch($sformatf("diff_hours %0d, expected %0d",
                                                  m_diff_hours, want.hours));
                    if (m_diff_minutes !== want.minutes)
                        report_mismatch($sformatf("diff_minutes %0d, expected %0d",
                                                  m_diff_minutes, want.minutes));
                    if (m_diff_seconds !== want.seconds)
                        report_mismatch($sformatf("diff_seconds %0d, expected %0d",
                                                  m_diff_seconds, want.seconds));
                end
            end
            if (s_valid && s_ready)
                countdown_q.push_back(countdown_of(
                    s_now_day, s_now_month, s_now_year,
                    s_now_hour, s_now_minute, s_now_second,
                    s_alarm_day, s_alarm_month, s_alarm_year,
                    s_alarm_hour, s_alarm_minute, s_alarm_second));
        end
        outstanding <= countdown_q.size();
    end

endmodule

### bench/tb_alarm_countdown_difference_unit.sv
// Testbench top for the alarm countdown difference unit: clock, reset, date-time stimulus,
// result-side stalls and the verdict. Depends on the unit and acdu_countdown_checker.
`timescale 1ns / 100ps

module tb_alarm_countdown_difference_unit;

    localparam int RANDOM_PER_PHASE = 343;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int QUIET_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 16;

    typedef struct packed {
        logic [4:0]  now_day;
        logic [3:0]  now_month;
        logic [13:0] now_year;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [5:0]  now_second;
        logic [4:0]  alarm_day;
        logic [3:0]  alarm_month;
        logic [13:0] alarm_year;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
        logic [5:0]  alarm_second;
    } date_pair_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [4:0]         s_now_day      = '0;
    logic [3:0]         s_now_month    = '0;
    logic [13:0]        s_now_year     = '0;
    logic [4:0]         s_now_hour     = '0;
    logic [5:0]         s_now_minute   = '0;
    logic [5:0]         s_now_second   = '0;
    logic [4:0]         s_alarm_day    = '0;
    logic [3:0]         s_alarm_month  = '0;
    logic [13:0]        s_alarm_year   = '0;
    logic [4:0]         s_alarm_hour   = '0;
    logic [5:0]         s_alarm_minute = '0;
    logic [5:0]         s_alarm_second = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [14:0] m_diff_years;
    logic signed [4:0]  m_diff_months;
    logic signed [5:0]  m_diff_days;
    logic [4:0]         m_diff_hours;
    logic [5:0]         m_diff_minutes;
    logic [5:0]         m_diff_seconds;

    int fail_count;
    int outstanding;
    int send_gap_pct   = 0;
    int recv_gap_pct   = 0;
    bit hold_off_req   = 1'b0;
    bit hold_off_taken = 1'b0;
    int quiet_cycles   = 0;

    alarm_countdown_difference_unit u_top (.*);

    acdu_countdown_checker u_check (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stop if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) < recv_gap_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    function automatic date_pair_t pair(
        input int nd, input int nm, input int ny, input int nh, input int nmin, input int nsec,
        input int ad, input int am, input int ay, input int ah, input int amin, input int asec);
        date_pair_t p;
        p.now_day      = 5'(nd);
        p.now_month    = 4'(nm);
        p.now_year     = 14'(ny);
        p.now_hour     = 5'(nh);
        p.now_minute   = 6'(nmin);
        p.now_second   = 6'(nsec);
        p.alarm_day    = 5'(ad);
        p.alarm_month  = 4'(am);
        p.alarm_year   = 14'(ay);
        p.alarm_hour   = 5'(ah);
        p.alarm_minute = 6'(amin);
        p.alarm_second = 6'(asec);
        return p;
    endfunction

    function automatic int random_year();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return $urandom_range(16383);
        else if (sel == 1)
            return $urandom_range(10010, 9990);
        return $urandom_range(9999);
    endfunction

    function automatic int random_month();
        return ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
    endfunction

    function automatic int random_day();
        return ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(31, 1);
    endfunction

    function automatic int random_hour();
        return ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
    endfunction

    function automatic int random_minsec();
        return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
    endfunction

    function automatic date_pair_t random_pair();
        int ny;
        int ay;
        ny = random_year();
        // half the alarms land within a couple of years so every split field gets exercised
        if ($urandom_range(1) == 0) begin
            ay = ny + $urandom_range(4) - 2;
            if (ay < 0)
                ay = 0;
            if (ay > 16383)
                ay = 16383;
        end else begin
            ay = random_year();
        end
        return pair(random_day(), random_month(), ny,
                    random_hour(), random_minsec(), random_minsec(),
                    random_day(), random_month(), ay,
                    random_hour(), random_minsec(), random_minsec());
    endfunction

    task automatic send_beat(input date_pair_t b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_now_day      <= b.now_day;
        s_now_month    <= b.now_month;
        s_now_year     <= b.now_year;
        s_now_hour     <= b.now_hour;
        s_now_minute   <= b.now_minute;
        s_now_second   <= b.now_second;
        s_alarm_day    <= b.alarm_day;
        s_alarm_month  <= b.alarm_month;
        s_alarm_year   <= b.alarm_year;
        s_alarm_hour   <= b.alarm_hour;
        s_alarm_minute <= b.alarm_minute;
        s_alarm_second <= b.alarm_second;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    initial begin
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct = 27;
        recv_gap_pct <= 77;

        // field extremes
        send_beat(pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(pair(31, 15, 16383, 31, 63, 63, 31, 15, 16383, 31, 63, 63));
        send_beat(pair(0, 0, 0, 0, 0, 0, 31, 15, 16383, 31, 63, 63));
        send_beat(pair(31, 15, 16383, 31, 63, 63, 0, 0, 0, 0, 0, 0));
        // years past the cap collapse onto it
        send_beat(pair(1, 1, 9999, 0, 0, 0, 1, 1, 10000, 0, 0, 0));
        send_beat(pair(5, 7, 16383, 1, 2, 3, 5, 7, 9999, 1, 2, 3));
        // leap day handling around century years and year 0
        send_beat(pair(28, 2, 2000, 0, 0, 0, 1, 3, 2000, 0, 0, 0));
        send_beat(pair(28, 2, 1900, 0, 0, 0, 1, 3, 1900, 0, 0, 0));
        send_beat(pair(1, 3, 0, 0, 0, 0, 1, 3, 1, 0, 0, 0));
        send_beat(pair(1, 3, 399, 0, 0, 0, 1, 3, 400, 0, 0, 0));
        // month zero and one add nothing; past December counts 31 per month
        send_beat(pair(5, 0, 2023, 0, 0, 0, 5, 1, 2023, 0, 0, 0));
        send_beat(pair(1, 13, 2023, 0, 0, 0, 1, 1, 2024, 0, 0, 0));
        send_beat(pair(1, 15, 100, 0, 0, 0, 1, 12, 100, 0, 0, 0));
        send_beat(pair(1, 14, 2024, 0, 0, 0, 1, 3, 2025, 0, 0, 0));
        // day zero and days past month end are taken as given
        send_beat(pair(0, 3, 2023, 0, 0, 0, 31, 2, 2023, 0, 0, 0));
        // time fields saturate
        send_beat(pair(1, 1, 2023, 31, 63, 63, 1, 1, 2023, 23, 59, 59));
        send_beat(pair(1, 1, 2023, 23, 59, 59, 1, 1, 2023, 0, 0, 0));
        send_beat(pair(1, 1, 2023, 0, 0, 0, 1, 1, 2023, 23, 59, 59));
        // alarm earlier than now gives negative parts
        send_beat(pair(20, 7, 2023, 10, 0, 0, 3, 7, 2023, 9, 30, 15));
        send_beat(pair(15, 9, 2024, 0, 0, 0, 1, 8, 2023, 0, 0, 0));
        // exact year and month boundaries of the split
        send_beat(pair(1, 1, 2023, 0, 0, 0, 1, 1, 2024, 0, 0, 0));
        send_beat(pair(1, 1, 2023, 0, 0, 0, 31, 1, 2023, 0, 0, 0));
        send_beat(pair(15, 6, 2024, 12, 0, 0, 15, 6, 2024, 12, 0, 0));
        wait_drained();

        for (k = 0; k < RANDOM_PER_PHASE; k++)
            send_beat(random_pair());
        wait_drained();

        send_gap_pct = 77;
        recv_gap_pct <= 27;
        for (k = 0; k < RANDOM_PER_PHASE; k++)
            send_beat(random_pair());
        wait_drained();

        // full rate both sides; the long hold-off fills the pipe and stalls the input
        send_gap_pct = 0;
        recv_gap_pct <= 0;
        hold_off_req <= 1'b1;
        for (k = 0; k < RANDOM_PER_PHASE; k++)
            send_beat(random_pair());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/acdu_pkg.sv
src/acdu_day_count.sv
src/acdu_day_split.sv
src/acdu_tod_diff.sv
src/alarm_countdown_difference_unit.sv
src/acdu_checker.sv
bench/acdu_countdown_checker.sv
bench/tb_alarm_countdown_difference_unit.sv
